[hdl/fpbs_pkg.sv]
`timescale 1ns / 1ps

package fpbs_pkg;

    localparam int TS_W       = 32;
    localparam int PERIOD_W   = 28;
    localparam int GAIN_W     = 16;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;
    localparam int TDATA_W    = 32;

    // floor(x / 5) = (x * RECIP_5) >> RECIP_SHIFT for any 32-bit x
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP_5 = 32'hCCCC_CCCD;

    localparam logic [PERIOD_W-1:0] NOMINAL_RESET = 28'd3145728;
    localparam logic [GAIN_W-1:0]   GAIN_RESET    = 16'd1311;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOMINAL_CELL = 2'd0,
        REG_FREQ_GAIN    = 2'd1,
        REG_TRACK_ENABLE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0]    cells;
        logic [PERIOD_W-1:0] period;
    } fpbs_entry_t;

    // floor(4 * r / 5) for a remainder of a division by five
    function automatic logic [2:0] frac4_5(input logic [2:0] r);
        logic [2:0] res;
        case (r)
            3'd2:    res = 3'd1;
            3'd3:    res = 3'd2;
            3'd4:    res = 3'd3;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

endpackage

[hdl/fpbs_front.sv]
`timescale 1ns / 1ps

module fpbs_front
    import fpbs_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_CELLS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TS_W-1:0]       in_time,
    output logic                  push_valid,
    input  logic                  push_full,
    output fpbs_entry_t           push_entry
);

    localparam int DW    = TS_W + FRAC_BITS;
    localparam int TW    = DW + 1;
    localparam int NW    = $clog2(MAX_CELLS + 1);
    localparam int NPW   = PERIOD_W + NW;
    localparam int ML    = DW / 2;
    localparam int MH    = DW - ML;
    localparam int XW    = DW + GAIN_W;
    localparam int DIG   = 8;
    localparam int STEPS = (DW + DIG - 1) / DIG;
    localparam int DIVW  = STEPS * DIG;
    localparam int SCW   = $clog2(STEPS);
    localparam int SW    = DIVW + 2;
    localparam int QW    = PERIOD_W + RECIP_W - RECIP_SHIFT;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_COUNT  = 10'b0000000010,
        ST_ERR    = 10'b0000000100,
        ST_MUL_LO = 10'b0000001000,
        ST_MUL_HI = 10'b0000010000,
        ST_SUM    = 10'b0000100000,
        ST_DIV    = 10'b0001000000,
        ST_UPD    = 10'b0010000000,
        ST_CLAMP  = 10'b0100000000,
        ST_PUSH   = 10'b1000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [TS_W-1:0]       prev_time_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [PERIOD_W-1:0]   nominal_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic                  track_reg;

    logic [DW-1:0]         d_reg;
    logic [TW-1:0]         thr_reg;
    logic [NPW-1:0]        np_reg;
    logic [NW-1:0]         n_reg;
    logic [DW-1:0]         mag_reg;
    logic                  neg_reg;
    logic [ML+GAIN_W-1:0]  plo_reg;
    logic [MH+GAIN_W-1:0]  phi_reg;
    logic [DIVW-1:0]       quo_reg;
    logic [NW-1:0]         rem_reg;
    logic [SCW-1:0]        step_reg;
    logic [SW-1:0]         psum_reg;

    logic [PERIOD_W-1:0]   nom_d_reg;
    logic [QW-1:0]         nq_reg;
    logic [PERIOD_W-1:0]   lo_reg;
    logic [PERIOD_W-1:0]   hi_reg;

    logic                  count_more;
    logic [DW:0]           err_u;
    logic [DW:0]           err_abs;
    logic [MH-1:0]         mul_a;
    logic [MH+GAIN_W-1:0]  mul_p;
    logic [XW-1:0]         x_sum;
    logic [NW-1:0]         div_rem;
    logic [NW:0]           div_try;
    logic [DIG-1:0]        div_digit;
    logic [DIG-1:0]        div_bits;
    logic [SW-1:0]         psum_next;
    logic [SW-1:0]         lo_ext;
    logic [SW-1:0]         hi_ext;
    logic [PERIOD_W-1:0]   clamp_val;
    logic [PERIOD_W+RECIP_W-1:0] div5_prod;
    logic [PERIOD_W-1:0]   five_q;
    logic [2:0]            rem5;
    logic [PERIOD_W-1:0]   lo_next;
    logic [PERIOD_W:0]     hi_raw;
    logic [PERIOD_W-1:0]   hi_next;

    assign in_ready         = (state_reg == ST_IDLE);
    assign push_valid       = (state_reg == ST_PUSH);
    assign push_entry.cells  = CNT_W'(n_reg);
    assign push_entry.period = period_reg;

    // next whole cell fits while 2*D >= (2n+1)*P
    assign count_more = (n_reg < NW'(MAX_CELLS)) && ({d_reg, 1'b0} >= thr_reg);

    assign err_u   = {1'b0, d_reg} - (DW+1)'(np_reg);
    assign err_abs = err_u[DW] ? (~err_u + 1'b1) : err_u;

    // one multiplier, low half of the error first, then the high half
    assign mul_a = (state_reg == ST_MUL_LO) ? MH'(mag_reg[ML-1:0]) : mag_reg[DW-1:ML];
    assign mul_p = mul_a * gain_reg;
    assign x_sum = {phi_reg, {ML{1'b0}}} + XW'(plo_reg);

    // eight quotient bits per cycle, divisor is the cell count
    always_comb begin
        div_rem   = rem_reg;
        div_digit = quo_reg[DIVW-1 -: DIG];
        div_bits  = '0;
        div_try   = '0;
        for (int i = DIG - 1; i >= 0; i--) begin
            div_try = {div_rem, div_digit[i]};
            if (div_try >= {1'b0, n_reg}) begin
                div_rem     = NW'(div_try - {1'b0, n_reg});
                div_bits[i] = 1'b1;
            end else begin
                div_rem = div_try[NW-1:0];
            end
        end
    end

    assign psum_next = neg_reg ? (SW'(period_reg) - SW'(quo_reg))
                               : (SW'(period_reg) + SW'(quo_reg));
    assign lo_ext    = SW'(lo_reg);
    assign hi_ext    = SW'(hi_reg);

    always_comb begin
        if ($signed(psum_reg) < $signed(lo_ext)) begin
            clamp_val = lo_reg;
        end else if ($signed(psum_reg) > $signed(hi_ext)) begin
            clamp_val = hi_reg;
        end else begin
            clamp_val = psum_reg[PERIOD_W-1:0];
        end
    end

    // period limits follow the nominal register through nom_d_reg/nq_reg, then lo_reg/hi_reg
    assign div5_prod = nominal_reg * RECIP_5;
    assign five_q    = PERIOD_W'({nq_reg, 2'b00}) + PERIOD_W'(nq_reg);
    assign rem5      = 3'(nom_d_reg - five_q);
    assign lo_next   = PERIOD_W'({nq_reg, 2'b00}) + PERIOD_W'(frac4_5(rem5));
    assign hi_raw    = (PERIOD_W+1)'({nq_reg, 2'b00}) + (PERIOD_W+1)'({nq_reg, 1'b0})
                     + (PERIOD_W+1)'(rem5);
    assign hi_next   = hi_raw[PERIOD_W] ? {PERIOD_W{1'b1}} : hi_raw[PERIOD_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_COUNT;
            ST_COUNT: begin
                if (!count_more) state_next = track_reg ? ST_ERR : ST_PUSH;
            end
            ST_ERR:    state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_DIV;
            ST_DIV:    if (step_reg == '0) state_next = ST_UPD;
            ST_UPD:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_PUSH;
            ST_PUSH:   if (!push_full) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_time_reg <= '0;
            period_reg    <= NOMINAL_RESET;
            nominal_reg   <= NOMINAL_RESET;
            gain_reg      <= GAIN_RESET;
            track_reg     <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (in_valid && in_ready) begin
                prev_time_reg <= in_time;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NOMINAL_CELL: begin
                        nominal_reg <= cfg_wdata[PERIOD_W-1:0];
                        period_reg  <= cfg_wdata[PERIOD_W-1:0];
                    end
                    REG_FREQ_GAIN:    gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_TRACK_ENABLE: track_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end else if (state_reg == ST_CLAMP) begin
                period_reg <= clamp_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        nom_d_reg <= nominal_reg;
        nq_reg    <= div5_prod[PERIOD_W+RECIP_W-1:RECIP_SHIFT];
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    d_reg   <= {in_time - prev_time_reg, {FRAC_BITS{1'b0}}};
                    thr_reg <= TW'({period_reg, 1'b0}) + TW'(period_reg);
                    np_reg  <= NPW'(period_reg);
                    n_reg   <= NW'(1);
                end
            end
            ST_COUNT: begin
                if (count_more) begin
                    n_reg   <= n_reg + 1'b1;
                    thr_reg <= thr_reg + TW'({period_reg, 1'b0});
                    np_reg  <= np_reg + NPW'(period_reg);
                end
            end
            ST_ERR: begin
                mag_reg <= err_abs[DW-1:0];
                neg_reg <= err_u[DW];
            end
            ST_MUL_LO: plo_reg <= mul_p[ML+GAIN_W-1:0];
            ST_MUL_HI: phi_reg <= mul_p;
            ST_SUM: begin
                quo_reg  <= DIVW'(x_sum[XW-1:GAIN_W]);
                rem_reg  <= '0;
                step_reg <= SCW'(STEPS - 1);
            end
            ST_DIV: begin
                quo_reg  <= {quo_reg[DIVW-DIG-1:0], div_bits};
                rem_reg  <= div_rem;
                step_reg <= step_reg - 1'b1;
            end
            ST_UPD:  psum_reg <= psum_next;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_push_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (n_reg != '0) && (n_reg <= NW'(MAX_CELLS)))
        else $error("front: cell count out of range at push");

    a_accept_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_COUNT) && (n_reg == NW'(1)))
        else $error("front: count did not start at one cell");
`endif

endmodule

[hdl/fpbs_queue.sv]
`timescale 1ns / 1ps

module fpbs_queue
    import fpbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    input  fpbs_entry_t push_entry,
    output logic        full,
    input  logic        pop_req,
    output logic        pop_valid,
    output fpbs_entry_t pop_entry
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    fpbs_entry_t     entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = entries_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_req && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entries_reg[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_req |-> (count_reg != '0) && (count_reg <= (AW+1)'(DEPTH)))
        else $error("queue: pop from empty queue");
`endif

endmodule

[hdl/fpbs_back.sv]
`timescale 1ns / 1ps

module fpbs_back
    import fpbs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  fpbs_entry_t         q_entry,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_bit,
    output logic [PERIOD_W-1:0] out_period
);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PERIOD_W-1:0] per_reg;
    logic                out_valid_reg;
    logic                out_bit_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic                emit;
    logic                finish;

    // output register frees when empty or being taken this cycle
    assign emit   = busy_reg && (!out_valid_reg || out_ready);
    assign finish = emit && (cnt_reg == CNT_W'(1));
    assign q_pop  = q_valid && (!busy_reg || finish);

    assign out_valid  = out_valid_reg;
    assign out_bit    = out_bit_reg;
    assign out_period = out_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cnt_reg <= q_entry.cells;
            per_reg <= q_entry.period;
        end else if (emit) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (emit) begin
            // the transition lands in the final cell of the run
            out_bit_reg    <= (cnt_reg == CNT_W'(1));
            out_period_reg <= per_reg;
        end
    end

`ifndef SYNTHESIS
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0))
        else $error("back: run counter empty while busy");
`endif

endmodule

[hdl/flux_pll_bit_separator_top.sv]
`timescale 1ns / 1ps

// Flux bit separator: each s_ item is the absolute sample tick of one flux transition.
// The block divides the gap to the previous transition by a tracked cell period
// (unsigned Q.FRAC_BITS ticks), rounds to 1..MAX_CELLS cells and emits one m_ item
// per cell: zeros, then a one flagged with tlast, each carrying the period after
// this transition's update. With tracking on the period moves by the gain-weighted
// timing error over the cell count, held within 0.8x..1.2x of nominal_cell;
// writing nominal_cell reloads the period. In the front end a transition passes the
// one-compare-per-cell count loop and, with tracking on, the shared multiplier and the
// eight-bit-per-cycle divider. A two-entry queue lets the output side emit one bit per
// cycle while m_tready stays high and the next gap is measured.

module flux_pll_bit_separator_top
    import fpbs_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_CELLS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TS_W-1:0]       s_tdata,   // [31:0] timestamp
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [0] cell_bit, [28:1] tracked_period
    output logic                  m_tlast
);

    logic                push_valid;
    logic                push_full;
    fpbs_entry_t         push_entry;
    logic                q_valid;
    logic                q_pop;
    fpbs_entry_t         q_entry;
    logic                out_bit;
    logic [PERIOD_W-1:0] out_period;

    fpbs_front #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_time    (s_tdata),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_entry (push_entry)
    );

    fpbs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (push_full),
        .pop_req    (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    fpbs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_bit    (out_bit),
        .out_period (out_period)
    );

    assign m_tdata = {{(TDATA_W-PERIOD_W-1){1'b0}}, out_period, out_bit};
    assign m_tlast = out_bit;

endmodule
